// ===== design/gtg_pkg.sv =====
// package: shared types, constants and tables for the go-to-goal controller
`timescale 1ns / 1ps
`default_nettype none
package gtg_pkg;

  // default parameter values
  localparam int PosFracBitsDef   = 16;
  localparam int AngleFracBitsDef = 12;
  localparam int CordicIterDef    = 16;

  // fixed field widths
  localparam int PosW   = 32;
  localparam int HeadW  = 15;
  localparam int LinW   = 15;
  localparam int AngW   = 16;
  localparam int TolW   = 23;
  localparam int GainW  = 15;
  localparam int CfgW   = 23;
  localparam int GainFrac = 12;

  // cordic working width: 33-bit differences plus growth
  localparam int CordW  = 36;
  localparam int ZW     = 34;
  localparam int AtanLen = 24;
  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;

  // input modes
  localparam logic [1:0] ModePose = 2'd0;
  localparam logic [1:0] ModeGoal = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;

  // phases
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhDrive = 2'd1;
  localparam logic [1:0] PhTurn  = 2'd2;

  // config register indexes
  localparam logic [2:0] RegPosTol = 3'd0;
  localparam logic [2:0] RegYawTol = 3'd1;
  localparam logic [2:0] RegCruise = 3'd2;
  localparam logic [2:0] RegKp     = 3'd3;
  localparam logic [2:0] RegKd     = 3'd4;

  // datapath commands from the controller
  typedef struct packed {
    logic load_pose;
    logic load_goal;
    logic cordic_init;
    logic cordic_step;
    logic cordic_done;
    logic dist_mul;
    logic dist_sum;
    logic drive_dec;
    logic turn_mul;
    logic turn_sum;
    logic turn_dec;
  } gtg_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic [1:0] phase;
    logic       need_turn;
  } gtg_sts_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/gtg_ctrl.sv =====
// controller: sequences pose, goal and tick beats through the datapath
`timescale 1ns / 1ps
`default_nettype none
module gtg_ctrl #(
  parameter int CORDIC_ITERATIONS = gtg_pkg::CordicIterDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [1:0]        in_mode,
  input  wire logic              out_busy,
  input  wire gtg_pkg::gtg_sts_t sts,
  output gtg_pkg::gtg_cmd_t      cmd,
  output logic                   in_ready,
  output logic                   res_valid
);
  import gtg_pkg::*;

  localparam int IterN = (CORDIC_ITERATIONS < AtanLen) ? CORDIC_ITERATIONS : AtanLen;
  localparam int CntW  = $clog2(IterN + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CINIT = 9'b000000010,
    S_CITER = 9'b000000100,
    S_CDONE = 9'b000001000,
    S_DMUL  = 9'b000010000,
    S_DSUM  = 9'b000100000,
    S_DDEC  = 9'b001000000,
    S_TMUL  = 9'b010000000,
    S_TSUM  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // turn sum state also performs the turn decision
  assign in_ready = (state_r == S_IDLE) && !out_busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            ModePose: cmd.load_pose = 1'b1;
            ModeGoal: begin
              cmd.load_goal = 1'b1;
              state_nxt = S_CINIT;
            end
            ModeTick: begin
              if (sts.phase == PhDrive) state_nxt = S_DMUL;
              else if (sts.phase == PhTurn) state_nxt = S_TMUL;
            end
            default: ;
          endcase
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_CITER;
      end
      S_CITER: begin
        cmd.cordic_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(IterN - 1)) state_nxt = S_CDONE;
      end
      S_CDONE: begin
        cmd.cordic_done = 1'b1;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.dist_mul = 1'b1;
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        cmd.dist_sum = 1'b1;
        state_nxt = S_DDEC;
      end
      S_DDEC: begin
        cmd.drive_dec = 1'b1;
        // datapath flags when the drive evaluation hands over to a turn
        if (sts.need_turn) state_nxt = S_TMUL;
        else begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TMUL: begin
        cmd.turn_mul = 1'b1;
        state_nxt = S_TSUM;
      end
      S_TSUM: begin
        cmd.turn_sum = 1'b1;
        cmd.turn_dec = 1'b1;
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/gtg_dp.sv =====
// datapath: pose and goal state, iterative cordic atan2, distance and pd math
`timescale 1ns / 1ps
`default_nettype none
module gtg_dp #(
  parameter int ANGLE_FRAC_BITS   = gtg_pkg::AngleFracBitsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gtg_pkg::gtg_cmd_t                 cmd,
  input  wire logic signed [gtg_pkg::PosW-1:0]   in_pos_x,
  input  wire logic signed [gtg_pkg::PosW-1:0]   in_pos_y,
  input  wire logic signed [gtg_pkg::HeadW-1:0]  in_heading,
  input  wire logic signed [gtg_pkg::PosW-1:0]   in_goal_x,
  input  wire logic signed [gtg_pkg::PosW-1:0]   in_goal_y,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [gtg_pkg::CfgW-1:0]          cfg_wdata,
  output gtg_pkg::gtg_sts_t                      sts,
  output logic [gtg_pkg::LinW-1:0]               res_linear,
  output logic signed [gtg_pkg::AngW-1:0]        res_angular,
  output logic [1:0]                             res_phase,
  output logic                                   res_sat
);
  import gtg_pkg::*;

  localparam int Shift = 30 - ANGLE_FRAC_BITS;

  // config registers
  logic [TolW-1:0]  pos_tol_r;
  logic [GainW-1:0] yaw_tol_r, cruise_r, kp_r, kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_r <= 23'd11141;
      yaw_tol_r <= 15'd205;
      cruise_r  <= 15'd1229;
      kp_r      <= 15'd6144;
      kd_r      <= 15'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPosTol: pos_tol_r <= cfg_wdata;
        RegYawTol: yaw_tol_r <= cfg_wdata[GainW-1:0];
        RegCruise: cruise_r  <= cfg_wdata[GainW-1:0];
        RegKp:     kp_r      <= cfg_wdata[GainW-1:0];
        RegKd:     kd_r      <= cfg_wdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic signed [PosW-1:0] cur_x_r, cur_y_r, gx_r, gy_r;
  logic signed [HeadW-1:0] head_r;
  logic signed [AngW-1:0] bear_r, prev_r;
  logic [1:0] phase_r;
  logic [LinW-1:0] held_r;

  // cordic registers
  logic signed [CordW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [4:0] it_r;
  logic czero_r;

  // differences
  logic signed [PosW:0] dx, dy;
  assign dx = {gx_r[PosW-1], gx_r} - {cur_x_r[PosW-1], cur_x_r};
  assign dy = {gy_r[PosW-1], gy_r} - {cur_y_r[PosW-1], cur_y_r};

  logic signed [AngW:0] err;
  assign err = {bear_r[AngW-1], bear_r} - AngW'(0) - {{2{head_r[HeadW-1]}}, head_r};
  logic [AngW:0] err_mag;
  assign err_mag = err[AngW] ? (AngW+1)'(0) - err : err;

  // cordic step
  logic signed [CordW-1:0] sx, sy;
  assign sx = cx_r >>> it_r;
  assign sy = cy_r >>> it_r;

  logic signed [ZW-1:0] zr;
  assign zr = cz_r + (ZW'(1) <<< (Shift - 1));

  // distance products
  logic [PosW:0] ax, ay;
  logic [2*PosW+1:0] sqx_r, sqy_r;
  logic [2*PosW+2:0] dsum;
  logic [2*TolW-1:0] tol_sq;
  logic far_r;
  assign ax = dx[PosW] ? (PosW+1)'(0) - dx : dx;
  assign ay = dy[PosW] ? (PosW+1)'(0) - dy : dy;
  assign dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign tol_sq = pos_tol_r * pos_tol_r;

  // pd products
  logic signed [AngW+GainW+2:0] pterm_r, dterm_r;
  logic signed [AngW+1:0] derr;
  logic signed [AngW+GainW+3:0] asum;
  logic signed [AngW+GainW+3:0] ashr;
  assign derr = {err[AngW], err} - {{2{prev_r[AngW-1]}}, prev_r};
  assign asum = {pterm_r[AngW+GainW+2], pterm_r} - {dterm_r[AngW+GainW+2], dterm_r}
              + (AngW+GainW+4)'(1 << (GainFrac - 1));
  assign ashr = asum >>> GainFrac;

  logic [AngW:0] yaw_ext;
  assign yaw_ext = {2'b00, yaw_tol_r};

  // drive evaluation hands over to a turn when far and heading is off
  logic need_turn;
  assign need_turn = far_r && (err_mag > yaw_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0; cur_y_r <= '0; head_r <= '0;
      gx_r <= '0; gy_r <= '0; bear_r <= '0; prev_r <= '0;
      phase_r <= PhIdle; held_r <= '0;
      res_linear <= '0; res_angular <= '0; res_phase <= PhIdle; res_sat <= 1'b0;
    end else begin
      if (cmd.load_pose) begin
        cur_x_r <= in_pos_x; cur_y_r <= in_pos_y; head_r <= in_heading;
      end
      if (cmd.load_goal) begin
        gx_r <= in_goal_x; gy_r <= in_goal_y;
      end
      if (cmd.cordic_done) bear_r <= czero_r ? '0 : AngW'(zr >>> Shift);
      // drive decision
      if (cmd.drive_dec) begin
        if (!far_r) begin
          phase_r <= PhIdle; held_r <= '0;
          res_linear <= '0; res_angular <= '0; res_phase <= PhIdle; res_sat <= 1'b0;
        end else if (need_turn) begin
          phase_r <= PhTurn; prev_r <= '0;
        end else begin
          phase_r <= PhDrive; held_r <= cruise_r;
          res_linear <= cruise_r; res_angular <= '0; res_phase <= PhDrive;
          res_sat <= 1'b0;
        end
      end
      // turn decision
      if (cmd.turn_dec) begin
        res_linear <= held_r;
        if (err_mag < yaw_ext) begin
          phase_r <= PhDrive;
          res_angular <= '0; res_phase <= PhDrive; res_sat <= 1'b0;
        end else begin
          prev_r <= AngW'(err);
          res_phase <= PhTurn;
          if (ashr > 32767) begin
            res_angular <= 16'sh7FFF; res_sat <= 1'b1;
          end else if (ashr < -32768) begin
            res_angular <= -16'sh8000; res_sat <= 1'b1;
          end else begin
            res_angular <= AngW'(ashr); res_sat <= 1'b0;
          end
        end
      end
    end
  end

  // cordic, distance and product registers
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      it_r <= '0;
      czero_r <= (dx == 0) && (dy == 0);
      if (dx[PosW]) begin
        cx_r <= CordW'(-dx); cy_r <= CordW'(-dy);
        cz_r <= dy[PosW] ? -PiQ30 : PiQ30;
      end else begin
        cx_r <= CordW'(dx); cy_r <= CordW'(dy); cz_r <= '0;
      end
    end
    if (cmd.cordic_step) begin
      it_r <= it_r + 5'd1;
      if (cy_r > 0) begin
        cx_r <= cx_r + sy; cy_r <= cy_r - sx; cz_r <= cz_r + atan_q30(it_r);
      end else begin
        cx_r <= cx_r - sy; cy_r <= cy_r + sx; cz_r <= cz_r - atan_q30(it_r);
      end
    end
    if (cmd.dist_mul) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
      far_r <= (ax > {{(PosW+1-TolW){1'b0}}, pos_tol_r})
            || (ay > {{(PosW+1-TolW){1'b0}}, pos_tol_r});
    end
    if (cmd.dist_sum) begin
      far_r <= far_r || (dsum > {{(2*PosW+3-2*TolW){1'b0}}, tol_sq});
    end
    if (cmd.turn_mul) begin
      pterm_r <= (AngW+GainW+3)'($signed({1'b0, kp_r}) * err);
      dterm_r <= (AngW+GainW+3)'($signed({1'b0, kd_r}) * derr);
    end
  end

  assign sts.phase = phase_r;
  assign sts.need_turn = need_turn;
endmodule
`default_nettype wire

// ===== design/go_to_goal_heading_pd_controller.sv =====
// top level: go-to-goal controller with pd heading loop and output register
// A pose beat latches position and heading and gives no result. A goal beat
// stores the goal, runs an iterative cordic atan2 (one rotation per cycle)
// and then a drive evaluation, giving one result, which follows a turn
// evaluation when the drive evaluation hands over to a turn. A tick beat gives
// one result while driving (drive evaluation, with the same hand-over) or
// turning (turn evaluation), and none when idle. One beat is worked at a time;
// the cordic loop sets the goal latency. Results wait in an output register,
// and a new beat is taken the cycle after that register is read.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_heading_pd_controller #(
  parameter int ANGLE_FRAC_BITS   = gtg_pkg::AngleFracBitsDef,
  parameter int CORDIC_ITERATIONS = gtg_pkg::CordicIterDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[1:0], pos_x[33:2], pos_y[65:34], heading[80:66],
  // goal_x[112:81], goal_y[144:113], zero fill to 152
  input  wire logic [151:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // linear_cmd[14:0], angular_cmd[30:15], phase[32:31], saturated[33], fill to 40
  output logic [39:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [22:0]  cfg_wdata
);
  import gtg_pkg::*;

  gtg_cmd_t cmd;
  gtg_sts_t sts;
  logic in_fire, res_valid, out_valid_r;
  logic [LinW-1:0] res_linear;
  logic signed [AngW-1:0] res_angular;
  logic [1:0] res_phase;
  logic res_sat;

  assign in_fire = in_tvalid && in_tready;

  gtg_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_mode(in_tdata[1:0]), .out_busy(out_valid_r),
    .sts, .cmd, .in_ready(in_tready), .res_valid
  );

  gtg_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_pos_x(in_tdata[33:2]), .in_pos_y(in_tdata[65:34]),
    .in_heading(in_tdata[80:66]), .in_goal_x(in_tdata[112:81]),
    .in_goal_y(in_tdata[144:113]),
    .cfg_we, .cfg_index, .cfg_wdata, .sts,
    .res_linear, .res_angular, .res_phase, .res_sat
  );

  // output valid flag, set on the edge that writes the result fields
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_valid) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, res_sat, res_phase, res_angular, res_linear};
endmodule
`default_nettype wire

// ===== dv/go_to_goal_heading_pd_controller_checker.sv =====
// checker: predicts controller commands from observed beats and compares them
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_heading_pd_controller_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [151:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [39:0]  out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [22:0]  cfg_wdata,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);
  import gtg_pkg::*;

  typedef struct {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic [1:0]         ph;
    logic               sat;
  } cmd_t;

  cmd_t cmd_queue[$];

  // controller registers
  longint tol_pos, tol_yaw, cruise, kp, kd;
  longint px, py, hdg, gx, gy, bearing, last_err, held_lin;
  logic [1:0] ctl_ph;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 843314856;   1: return 497837829;  2: return 263043836;
      3: return 133525158;   4: return 67021686;   5: return 33543515;
      6: return 16775850;    7: return 8388437;    8: return 4194282;
      9: return 2097149;     10: return 1048575;   11: return 524287;
      12: return 262143;     13: return 131071;    14: return 65535;
      default: return 32767;
    endcase
  endfunction

  // bearing in Q4.12, rounded from a Q30 accumulator
  function automatic longint bearing_of(longint dy, longint dx);
    longint x, y, z, nx;
    x = dx; y = dy; z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      x = -dx; y = -dy;
      z = (dy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_step(i);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_step(i);
      end
      x = nx;
    end
    return shr(z + (64'sd1 << 17), 18);
  endfunction

  function automatic cmd_t make_cmd(longint l, longint a, logic [1:0] p, logic s);
    cmd_t c;
    c.lin = l[14:0]; c.ang = a[15:0]; c.ph = p; c.sat = s;
    return c;
  endfunction

  function automatic cmd_t turn_cmd();
    longint e, m, a;
    logic s;
    e = bearing - hdg;
    m = e < 0 ? -e : e;
    s = 1'b0;
    if (m < tol_yaw) begin
      ctl_ph = PhDrive;
      return make_cmd(held_lin, 0, PhDrive, 1'b0);
    end
    a = shr(kp * e - kd * (e - last_err) + 2048, 12);
    if (a > 32767) begin a = 32767; s = 1'b1; end
    if (a < -32768) begin a = -32768; s = 1'b1; end
    last_err = e;
    return make_cmd(held_lin, a, PhTurn, s);
  endfunction

  function automatic cmd_t drive_cmd();
    longint dx, dy, e, m;
    dx = gx - px; dy = gy - py;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx <= tol_pos && dy <= tol_pos && dx * dx + dy * dy <= tol_pos * tol_pos) begin
      ctl_ph = PhIdle; held_lin = 0;
      return make_cmd(0, 0, PhIdle, 1'b0);
    end
    e = bearing - hdg;
    m = e < 0 ? -e : e;
    if (m > tol_yaw) begin
      ctl_ph = PhTurn; last_err = 0;
      return turn_cmd();
    end
    ctl_ph = PhDrive; held_lin = cruise;
    return make_cmd(cruise, 0, PhDrive, 1'b0);
  endfunction

  // watch config, inputs and results
  always @(posedge clk) begin
    cmd_t got, want;
    logic [1:0] md;
    if (!rst_n) begin
      tol_pos <= 11141; tol_yaw <= 205; cruise <= 1229; kp <= 6144; kd <= 8192;
      px = 0; py = 0; hdg = 0; gx = 0; gy = 0; bearing = 0; last_err = 0;
      held_lin = 0; ctl_ph = PhIdle;
      cmd_queue.delete();
      fail_count <= 0; result_count <= 0; pending_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegPosTol: tol_pos <= cfg_wdata;
          RegYawTol: tol_yaw <= cfg_wdata[14:0];
          RegCruise: cruise <= cfg_wdata[14:0];
          RegKp:     kp <= cfg_wdata[14:0];
          RegKd:     kd <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        md = in_tdata[1:0];
        if (md == ModePose) begin
          px = $signed(in_tdata[33:2]); py = $signed(in_tdata[65:34]);
          hdg = $signed(in_tdata[80:66]);
        end else if (md == ModeGoal) begin
          gx = $signed(in_tdata[112:81]); gy = $signed(in_tdata[144:113]);
          bearing = bearing_of(gy - py, gx - px);
          cmd_queue.push_back(drive_cmd());
        end else if (md == ModeTick) begin
          if (ctl_ph == PhDrive) cmd_queue.push_back(drive_cmd());
          else if (ctl_ph == PhTurn) cmd_queue.push_back(turn_cmd());
        end
      end
      if (out_tvalid && out_tready) begin
        got = make_cmd(out_tdata[14:0], $signed(out_tdata[30:15]), out_tdata[32:31],
                       out_tdata[33]);
        result_count <= result_count + 1;
        if (cmd_queue.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (got.lin !== want.lin || got.ang !== want.ang || got.ph !== want.ph ||
              got.sat !== want.sat)
            fail_count <= fail_count + 1;
          if (got.lin !== want.lin)
            $error("linear_cmd expected %0d got %0d", want.lin, got.lin);
          if (got.ang !== want.ang)
            $error("angular_cmd expected %0d got %0d", want.ang, got.ang);
          if (got.ph !== want.ph)
            $error("phase expected %0d got %0d", want.ph, got.ph);
          if (got.sat !== want.sat)
            $error("saturated expected %0d got %0d", want.sat, got.sat);
        end
      end
      pending_count <= cmd_queue.size();
    end
  end
endmodule
`default_nettype wire

// ===== dv/go_to_goal_heading_pd_controller_test.sv =====
// testbench top: stimulus, idling, config phases and final verdict
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_heading_pd_controller_test;
  import gtg_pkg::*;

  // codes outside the defined sets
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [2:0] RegUnused  = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [151:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_wdata = '0;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int beat_count = 0;
  int hold_cycles = 0;
  logic long_hold = 1'b0;

  always #2 clk = ~clk;

  go_to_goal_heading_pd_controller DUT (.*);

  go_to_goal_heading_pd_controller_checker checker_i (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (long_hold) begin
      hold_cycles <= 400;
      long_hold <= 1'b0;
      out_tready <= 1'b0;
    end else if (cycle_count % 2000 < 500) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_beat(input logic [1:0] md, input logic [31:0] x, input logic [31:0] y,
                           input logic [14:0] h, input logic [31:0] a, input logic [31:0] b);
    int gap;
    in_tdata <= {7'd0, b, a, h, y, x, md};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beat_count++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [14:0] rand_heading();
    int v;
    v = $urandom_range(0, 25736) - 12868;
    return v[14:0];
  endfunction

  // random mix of pose, goal, tick and unused-mode beats; pose and goal use separate random points
  task automatic random_run(input int n, input int spread);
    logic [31:0] bx, by;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      bx = $urandom; by = $urandom;
      if (k < 6)
        send_beat(ModePose, bx + $urandom_range(0, spread), by - $urandom_range(0, spread),
                  rand_heading(), $urandom, $urandom);
      else if (k < 9)
        send_beat(ModeGoal, $urandom, $urandom, 15'($urandom), bx, by);
      else if (k < 18)
        send_beat(ModeTick, $urandom, $urandom, 15'($urandom), $urandom, $urandom);
      else if (k == 18)
        send_beat(ModeUnused, $urandom, $urandom, 15'($urandom), $urandom, $urandom);
      else
        send_beat(ModeGoal, $urandom, $urandom, 15'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extremes, zero vector, idle tick, unused mode
    send_beat(ModeTick, '0, '0, '0, '0, '0);
    send_beat(ModeUnused, '1, '1, '1, '1, '1);
    send_beat(ModeGoal, '0, '0, '0, '0, '0);
    send_beat(ModePose, 32'h8000_0000, 32'h7fff_ffff, 15'sd12868, '0, '0);
    send_beat(ModeGoal, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_beat(ModeTick, '0, '0, '0, '0, '0);
    send_beat(ModePose, 32'h0001_0000, '0, -15'sd12868, '0, '0);
    send_beat(ModeGoal, '0, '0, '0, 32'h8000_0000, 32'h0000_0001);
    send_beat(ModeTick, '0, '0, '0, '0, '0);
    send_beat(ModePose, '0, '0, '0, '0, '0);
    send_beat(ModeGoal, '0, '0, '0, 32'h0005_0000, '0);
    send_beat(ModeTick, '0, '0, '0, '0, '0);
    send_beat(ModeGoal, '0, '0, '0, 32'h0000_1000, '0);
    send_beat(ModeTick, '0, '0, '0, '0, '0);
    settle();

    // random phases at several settings, extremes included
    write_reg(RegPosTol, 23'd4194304); write_reg(RegYawTol, 15'd32767);
    write_reg(RegCruise, 15'd32767); write_reg(RegKp, 15'd32767);
    write_reg(RegKd, 15'd32767); write_reg(RegUnused, 23'h7fffff);
    random_run(300, 32'h0040_0000);
    long_hold <= 1'b1;
    random_run(150, 32'h0040_0000);
    settle();
    write_reg(RegPosTol, '0); write_reg(RegYawTol, '0);
    write_reg(RegCruise, '0); write_reg(RegKp, '0); write_reg(RegKd, '0);
    random_run(300, 4);
    settle();
    for (int p = 0; p < 4; p++) begin
      write_reg(RegPosTol, 23'($urandom_range(0, 4194304)));
      write_reg(RegYawTol, 23'($urandom_range(0, 32767)));
      write_reg(RegCruise, 23'($urandom_range(0, 32767)));
      write_reg(RegKp, 23'($urandom_range(0, 32767)));
      write_reg(RegKd, 23'($urandom_range(0, 32767)));
      random_run(250, 32'h0080_0000);
      settle();
    end

    $display("covered %0d input beats and %0d result beats over seven register settings",
             beat_count, result_count);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
